FILE: hdl/mode_slot_cyclic_scheduler_defines.svh
//------------------------------------------------------------------------------
// mode_slot_cyclic_scheduler_defines
// assertion macros shared by the scheduler rtl
//------------------------------------------------------------------------------
`ifndef MODE_SLOT_CYCLIC_SCHEDULER_DEFINES_SVH
`define MODE_SLOT_CYCLIC_SCHEDULER_DEFINES_SVH

// same-cycle implication, checked on every rising clk edge out of reset
`define MSC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every rising clk edge out of reset
`define MSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/msc_pkg.sv
//------------------------------------------------------------------------------
// msc_pkg
// shared widths, codes and types of the mode slot cyclic scheduler
//------------------------------------------------------------------------------
package msc_pkg;

    localparam int DEF_SLOTS_PER_MODE = 5;
    localparam int DEF_MODE_COUNT     = 4;

    localparam int TIME_W     = 32;
    localparam int CMD_W      = 2;
    localparam int MODE_W     = 2;
    localparam int KIND_W     = 2;
    localparam int SLOT_IDX_W = 3;

    localparam logic [TIME_W-1:0] PERIOD_RESET = TIME_W'(1000);

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK     = 2'd0,
        CMD_REGISTER = 2'd1,
        CMD_SELECT   = 2'd2
    } cmd_t;

    typedef enum logic [KIND_W-1:0] {
        EV_FIRED    = 2'd0,
        EV_OVERRUN  = 2'd1,
        EV_REJECTED = 2'd2
    } ev_kind_t;

    // result of the shared subtract / compare unit
    typedef struct packed {
        logic [TIME_W-1:0] diff;
        logic              ge;
    } cmp_result_t;

endpackage

FILE: hdl/msc_ram.sv
//------------------------------------------------------------------------------
// msc_ram
// generic single write port, single read port ram with registered read
//------------------------------------------------------------------------------
module msc_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 20
) (
    input  logic                                           clk,
    input  logic                                           wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   wr_addr,
    input  logic [DATA_W-1:0]                              wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   rd_addr,
    output logic [DATA_W-1:0]                              rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/msc_sub_unit.sv
//------------------------------------------------------------------------------
// msc_sub_unit
// shared 32-bit subtractor with unsigned greater-or-equal flag
//------------------------------------------------------------------------------
module msc_sub_unit
    import msc_pkg::*;
(
    input  logic [TIME_W-1:0] op_a,
    input  logic [TIME_W-1:0] op_b,
    output cmp_result_t       res
);

    logic [TIME_W:0] wide_diff;

    // borrow out of the top bit means a < b
    assign wide_diff = {1'b0, op_a} - {1'b0, op_b};
    assign res.diff  = wide_diff[TIME_W-1:0];
    assign res.ge    = ~wide_diff[TIME_W];

endmodule

FILE: hdl/mode_slot_cyclic_scheduler.sv
//------------------------------------------------------------------------------
// mode_slot_cyclic_scheduler
// time-triggered cyclic scheduler with per-mode slot tables
//------------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Register and select
// items finish in the cycle they are taken and busy never rises for them; a
// rejected registration shows its single event in the next cycle. A tick keeps
// busy high through a period check, an overrun pass over the n slots of the
// active mode (skipped when the period has not run out), a firing pass over
// the same slots and a flush; both passes are skipped when n is zero. Both
// passes step through the slots one at a time; the period check and the
// firing pass share one 32-bit subtract/compare unit, which also forms the
// elapsed time in the cycle the tick is taken. Slot offsets sit in a small
// ram with registered read, so the firing pass reads one slot ahead. Every
// event is shown for exactly one cycle with event_strobe high and cannot be
// held off; one event is kept back so that last can be set on the final
// event of an item, hence an event goes out in the cycle after the next
// event is found or after the flush state. The offset ram is not cleared at
// reset; only written slots are ever used, so there is no clearing pass. The
// period register may be written at any idle time; cfg_ready is always high.
//------------------------------------------------------------------------------
`include "mode_slot_cyclic_scheduler_defines.svh"

module mode_slot_cyclic_scheduler
    import msc_pkg::*;
#(
    parameter int SLOTS_PER_MODE = DEF_SLOTS_PER_MODE,
    parameter int MODE_COUNT     = DEF_MODE_COUNT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // command channel
    input  logic                  start,
    output logic                  busy,
    input  logic [CMD_W-1:0]      command,
    input  logic [TIME_W-1:0]     now_ms,
    input  logic [MODE_W-1:0]     mode,
    input  logic [TIME_W-1:0]     offset_ms,
    // period register write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [TIME_W-1:0]     cfg_data,
    // event channel
    output logic                  event_strobe,
    output logic [KIND_W-1:0]     event_kind,
    output logic [SLOT_IDX_W-1:0] slot_index,
    output logic [MODE_W-1:0]     event_mode,
    output logic                  last
);

    // table geometry
    localparam int TOTAL   = MODE_COUNT * SLOTS_PER_MODE;
    localparam int ADDR_W  = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int CNT_W   = $clog2(SLOTS_PER_MODE + 1);
    localparam int MIDX_W  = (MODE_COUNT > 1) ? $clog2(MODE_COUNT) : 1;
    localparam int MEXT_W  = (MIDX_W > MODE_W) ? MIDX_W : MODE_W;

    // one-hot sequencer states
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PCHK = 5'b00010,
        S_OVR  = 5'b00100,
        S_FCHK = 5'b01000,
        S_FIN  = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [TIME_W-1:0]   elapsed_reg, elapsed_next;
    logic [TIME_W-1:0]   period_reg, period_next;
    logic [TIME_W-1:0]   period_start_reg, period_start_next;
    logic [MODE_W-1:0]   active_mode_reg, active_mode_next;
    logic [CNT_W-1:0]    slot_count_reg [MODE_COUNT];
    logic [CNT_W-1:0]    slot_count_next [MODE_COUNT];
    logic [TOTAL-1:0]    armed_reg, armed_next;

    // one event held back until we know whether it is the final one
    logic                  pend_valid_reg, pend_valid_next;
    ev_kind_t              pend_kind_reg, pend_kind_next;
    logic [SLOT_IDX_W-1:0] pend_slot_reg, pend_slot_next;

    // registered event outputs
    logic                  ev_strobe_reg, ev_strobe_next;
    ev_kind_t              ev_kind_reg, ev_kind_next;
    logic [SLOT_IDX_W-1:0] ev_slot_reg, ev_slot_next;
    logic [MODE_W-1:0]     ev_mode_reg, ev_mode_next;
    logic                  ev_last_reg, ev_last_next;

    logic                  accept;
    logic [MEXT_W-1:0]     am_ext, in_ext;
    logic [MIDX_W-1:0]     am_idx, in_idx;
    logic                  mode_ok;
    logic [CNT_W-1:0]      reg_cnt;
    logic                  reg_room;
    logic [CNT_W-1:0]      idx_inc;
    logic                  scan_end;
    logic [CNT_W-1:0]      rd_idx;
    logic [ADDR_W-1:0]     cur_addr, rd_addr, wr_addr;
    logic                  ram_we;
    logic [TIME_W-1:0]     rd_offset;
    logic [TIME_W-1:0]     unit_a, unit_b;
    cmp_result_t           unit_res;

    // new event found this cycle
    logic                  hit_valid;
    ev_kind_t              hit_kind;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    // mode indexes, widened first so any mode count works
    assign am_ext  = MEXT_W'(active_mode_reg);
    assign am_idx  = am_ext[MIDX_W-1:0];
    assign in_ext  = MEXT_W'(mode);
    assign in_idx  = in_ext[MIDX_W-1:0];
    assign mode_ok = (int'(mode) < MODE_COUNT);

    assign reg_cnt  = mode_ok ? slot_count_reg[in_idx] : '0;
    assign reg_room = mode_ok && (int'(reg_cnt) < SLOTS_PER_MODE);
    assign wr_addr  = ADDR_W'(int'(in_idx) * SLOTS_PER_MODE + int'(reg_cnt));

    assign idx_inc  = idx_reg + CNT_W'(1);
    assign scan_end = (idx_inc == cnt_reg);
    assign cur_addr = ADDR_W'(int'(am_idx) * SLOTS_PER_MODE + int'(idx_reg));

    // firing pass reads one slot ahead; everywhere else slot 0 is prefetched
    assign rd_idx  = ((state_reg == S_FCHK) && !scan_end) ? idx_inc : '0;
    assign rd_addr = ADDR_W'(int'(am_idx) * SLOTS_PER_MODE + int'(rd_idx));

    msc_ram #(
        .DATA_W (TIME_W),
        .DEPTH  (TOTAL)
    ) u_offset_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (wr_addr),
        .wr_data (offset_ms),
        .rd_addr (rd_addr),
        .rd_data (rd_offset)
    );

    // shared unit operand select
    always_comb
    begin
        case (state_reg)
            S_IDLE:
            begin
                unit_a = now_ms;
                unit_b = period_start_reg;
            end
            S_PCHK:
            begin
                unit_a = elapsed_reg;
                unit_b = period_reg;
            end
            default:
            begin
                unit_a = elapsed_reg;
                unit_b = rd_offset;
            end
        endcase
    end

    msc_sub_unit u_sub (
        .op_a (unit_a),
        .op_b (unit_b),
        .res  (unit_res)
    );

    // sequencer and datapath next state
    always_comb
    begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        cnt_next          = cnt_reg;
        now_next          = now_reg;
        elapsed_next      = elapsed_reg;
        period_next       = period_reg;
        period_start_next = period_start_reg;
        active_mode_next  = active_mode_reg;
        slot_count_next   = slot_count_reg;
        armed_next        = armed_reg;
        ram_we            = 1'b0;
        hit_valid         = 1'b0;
        hit_kind          = EV_FIRED;

        pend_valid_next   = pend_valid_reg;
        pend_kind_next    = pend_kind_reg;
        pend_slot_next    = pend_slot_reg;
        ev_strobe_next    = 1'b0;
        ev_kind_next      = ev_kind_reg;
        ev_slot_next      = ev_slot_reg;
        ev_mode_next      = ev_mode_reg;
        ev_last_next      = ev_last_reg;

        if (cfg_valid && cfg_ready)
        begin
            period_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (command)
                        CMD_REGISTER:
                        begin
                            if (reg_room)
                            begin
                                ram_we                  = 1'b1;
                                armed_next[wr_addr]     = 1'b0;
                                slot_count_next[in_idx] = reg_cnt + CNT_W'(1);
                            end
                            else
                            begin
                                // table full or no such mode: single event
                                ev_strobe_next = 1'b1;
                                ev_kind_next   = EV_REJECTED;
                                ev_slot_next   = '0;
                                ev_mode_next   = mode;
                                ev_last_next   = 1'b1;
                            end
                        end
                        CMD_SELECT:
                        begin
                            if (mode_ok)
                            begin
                                active_mode_next = mode;
                            end
                        end
                        CMD_TICK:
                        begin
                            now_next     = now_ms;
                            elapsed_next = unit_res.diff;
                            cnt_next     = slot_count_reg[am_idx];
                            idx_next     = '0;
                            state_next   = S_PCHK;
                        end
                        default:
                        begin
                            // unused command code, ignored
                        end
                    endcase
                end
            end

            S_PCHK:
            begin
                idx_next = '0;
                if (unit_res.ge)
                begin
                    // period ran out: restart it at the tick time
                    period_start_next = now_reg;
                    elapsed_next      = '0;
                    state_next        = (cnt_reg == '0) ? S_FIN : S_OVR;
                end
                else
                begin
                    state_next = (cnt_reg == '0) ? S_FIN : S_FCHK;
                end
            end

            S_OVR:
            begin
                if (armed_reg[cur_addr])
                begin
                    hit_valid = 1'b1;
                    hit_kind  = EV_OVERRUN;
                end
                armed_next[cur_addr] = 1'b1;
                if (scan_end)
                begin
                    idx_next   = '0;
                    state_next = S_FCHK;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end

            S_FCHK:
            begin
                if (armed_reg[cur_addr] && unit_res.ge)
                begin
                    hit_valid            = 1'b1;
                    hit_kind             = EV_FIRED;
                    armed_next[cur_addr] = 1'b0;
                end
                if (scan_end)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end

            S_FIN:
            begin
                if (pend_valid_reg)
                begin
                    ev_strobe_next  = 1'b1;
                    ev_kind_next    = pend_kind_reg;
                    ev_slot_next    = pend_slot_reg;
                    ev_mode_next    = active_mode_reg;
                    ev_last_next    = 1'b1;
                    pend_valid_next = 1'b0;
                end
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // a new event pushes the held one out, not final
        if (hit_valid)
        begin
            if (pend_valid_reg)
            begin
                ev_strobe_next = 1'b1;
                ev_kind_next   = pend_kind_reg;
                ev_slot_next   = pend_slot_reg;
                ev_mode_next   = active_mode_reg;
                ev_last_next   = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_kind_next  = hit_kind;
            pend_slot_next  = SLOT_IDX_W'(idx_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            idx_reg          <= '0;
            cnt_reg          <= '0;
            now_reg          <= '0;
            elapsed_reg      <= '0;
            period_reg       <= PERIOD_RESET;
            period_start_reg <= '0;
            active_mode_reg  <= '0;
            for (int m = 0; m < MODE_COUNT; m++)
            begin
                slot_count_reg[m] <= '0;
            end
            armed_reg        <= '0;
            pend_valid_reg   <= 1'b0;
            pend_kind_reg    <= EV_FIRED;
            pend_slot_reg    <= '0;
            ev_strobe_reg    <= 1'b0;
            ev_kind_reg      <= EV_FIRED;
            ev_slot_reg      <= '0;
            ev_mode_reg      <= '0;
            ev_last_reg      <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            idx_reg          <= idx_next;
            cnt_reg          <= cnt_next;
            now_reg          <= now_next;
            elapsed_reg      <= elapsed_next;
            period_reg       <= period_next;
            period_start_reg <= period_start_next;
            active_mode_reg  <= active_mode_next;
            slot_count_reg   <= slot_count_next;
            armed_reg        <= armed_next;
            pend_valid_reg   <= pend_valid_next;
            pend_kind_reg    <= pend_kind_next;
            pend_slot_reg    <= pend_slot_next;
            ev_strobe_reg    <= ev_strobe_next;
            ev_kind_reg      <= ev_kind_next;
            ev_slot_reg      <= ev_slot_next;
            ev_mode_reg      <= ev_mode_next;
            ev_last_reg      <= ev_last_next;
        end
    end

    assign event_strobe = ev_strobe_reg;
    assign event_kind   = ev_kind_reg;
    assign slot_index   = ev_slot_reg;
    assign event_mode   = ev_mode_reg;
    assign last         = ev_last_reg;

    // a taken tick always runs the sequencer
    `MSC_ASSERT_NEXT(a_tick_goes_busy, start && !busy && command == CMD_TICK, busy, "tick not started")
    // nothing may stay held back once the block is idle
    `MSC_ASSERT_SAME(a_idle_no_pending, state_reg == S_IDLE, !pend_valid_reg, "event left behind")
    // slot scans stay within the registered slots
    `MSC_ASSERT_SAME(a_scan_in_range, state_reg == S_OVR || state_reg == S_FCHK, idx_reg < cnt_reg, "slot scan out of range")
    // fired and overrun events belong to the active mode
    `MSC_ASSERT_SAME(a_event_mode_active, event_strobe && event_kind != EV_REJECTED, event_mode == active_mode_reg, "event mode mismatch")

endmodule

FILE: tb/tb_mode_slot_cyclic_scheduler.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tb_mode_slot_cyclic_scheduler
// self-checking bench for the mode slot cyclic scheduler: a queue-fed driver
// issues register, select and tick items, a scoreboard model of the slot
// tables predicts the fired, overrun and rejected events of every accepted
// item, and a monitor compares each event strobe field by field in order
//------------------------------------------------------------------------------
module tb_mode_slot_cyclic_scheduler;
    import msc_pkg::*;

    localparam int          SLOTS_N      = DEF_SLOTS_PER_MODE;
    localparam int          MODES_N      = DEF_MODE_COUNT;
    localparam int          SETTLE_CYC   = 20;
    localparam int          DRAIN_LIMIT  = 5000;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    // command code with no meaning, must be ignored by the block
    localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [TIME_W-1:0] now_val;
        logic [MODE_W-1:0] mode_val;
        logic [TIME_W-1:0] off_val;
    } cmd_item_t;

    typedef struct packed {
        ev_kind_t              kind;
        logic [SLOT_IDX_W-1:0] slot;
        logic [MODE_W-1:0]     mode_id;
        logic                  last_flag;
    } sched_event_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // block inputs, known from time zero
    logic                  start     = 1'b0;
    logic [CMD_W-1:0]      command   = CMD_TICK;
    logic [TIME_W-1:0]     now_ms    = '0;
    logic [MODE_W-1:0]     mode      = '0;
    logic [TIME_W-1:0]     offset_ms = '0;
    logic                  cfg_valid = 1'b0;
    logic [TIME_W-1:0]     cfg_data  = '0;

    // block outputs
    logic                  busy;
    logic                  cfg_ready;
    logic                  event_strobe;
    logic [KIND_W-1:0]     event_kind;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic [MODE_W-1:0]     event_mode;
    logic                  last;

    // scoreboard copy of the scheduler state
    logic [2:0]        tab_count  [MODES_N]         = '{default: '0};
    logic [TIME_W-1:0] tab_offset [MODES_N*SLOTS_N] = '{default: '0};
    bit                tab_armed  [MODES_N*SLOTS_N] = '{default: 1'b0};
    logic [TIME_W-1:0] period_begin = '0;
    logic [MODE_W-1:0] act_mode     = '0;
    logic [TIME_W-1:0] period_cur   = PERIOD_RESET;

    // stimulus and expectation stores
    cmd_item_t    cmd_queue[$];
    sched_event_t expected_events[$];
    cmd_item_t    next_item;
    sched_event_t want;

    int          hold_cycles    = 0;
    bit          steady         = 1'b0;   // no sender gaps in the closing phase
    int          mismatch_count = 0;
    int unsigned cycle_count    = 0;
    logic [TIME_W-1:0] wall_ms  = '0;     // time base for generated ticks

    mode_slot_cyclic_scheduler uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .now_ms       (now_ms),
        .mode         (mode),
        .offset_ms    (offset_ms),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .event_strobe (event_strobe),
        .event_kind   (event_kind),
        .slot_index   (slot_index),
        .event_mode   (event_mode),
        .last         (last)
    );

    always #10 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic sched_event_t make_event(input ev_kind_t k, input int slot_i,
                                                input logic [MODE_W-1:0] md);
        sched_event_t ev;
        ev.kind      = k;
        ev.slot      = SLOT_IDX_W'(slot_i);
        ev.mode_id   = md;
        ev.last_flag = 1'b0;
        return ev;
    endfunction

    // updates the slot tables for one accepted item and queues its events
    task automatic predict_events(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] now_v,
                                  input logic [MODE_W-1:0] md, input logic [TIME_W-1:0] off_v);
        sched_event_t      evs[$];
        sched_event_t      tail;
        int                idx;
        int                base;
        int                cnt;
        logic [TIME_W-1:0] elapsed;
        case (cmd)
            CMD_REGISTER:
            begin
                if (int'(md) < MODES_N && int'(tab_count[md]) < SLOTS_N)
                begin
                    idx = int'(md) * SLOTS_N + int'(tab_count[md]);
                    tab_offset[idx] = off_v;
                    tab_armed[idx]  = 1'b0;
                    tab_count[md]   = tab_count[md] + 3'd1;
                end
                else
                begin
                    evs.push_back(make_event(EV_REJECTED, 0, md));
                end
            end
            CMD_SELECT:
            begin
                if (int'(md) < MODES_N)
                    act_mode = md;
            end
            CMD_TICK:
            begin
                base    = int'(act_mode) * SLOTS_N;
                cnt     = int'(tab_count[act_mode]);
                elapsed = now_v - period_begin;
                if (cnt > SLOTS_N)
                    cnt = SLOTS_N;
                // period ran out: report what is still armed, re-arm, restart
                if (elapsed >= period_cur)
                begin
                    for (int i = 0; i < cnt; i++)
                    begin
                        if (tab_armed[base+i])
                            evs.push_back(make_event(EV_OVERRUN, i, act_mode));
                        tab_armed[base+i] = 1'b1;
                    end
                    period_begin = now_v;
                    elapsed      = '0;
                end
                // fire armed slots whose offset has elapsed, in slot order
                for (int i = 0; i < cnt; i++)
                begin
                    if (tab_armed[base+i] && elapsed >= tab_offset[base+i])
                    begin
                        evs.push_back(make_event(EV_FIRED, i, act_mode));
                        tab_armed[base+i] = 1'b0;
                    end
                end
            end
            default: ;  // reserved command, ignored
        endcase
        if (evs.size() > 0)
        begin
            tail = evs.pop_back();
            tail.last_flag = 1'b1;
            evs.push_back(tail);
        end
        foreach (evs[i])
            expected_events.push_back(evs[i]);
    endtask

    task automatic push_item(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] now_v,
                             input logic [MODE_W-1:0] md, input logic [TIME_W-1:0] off_v);
        cmd_item_t it;
        it.cmd      = cmd;
        it.now_val  = now_v;
        it.mode_val = md;
        it.off_val  = off_v;
        cmd_queue.push_back(it);
    endtask

    // unused fields carry random bits so every input bit toggles
    task automatic push_tick(input logic [TIME_W-1:0] now_v);
        push_item(CMD_TICK, now_v, MODE_W'($urandom), $urandom);
    endtask

    task automatic push_register(input logic [MODE_W-1:0] md, input logic [TIME_W-1:0] off_v);
        push_item(CMD_REGISTER, $urandom, md, off_v);
    endtask

    task automatic push_select(input logic [MODE_W-1:0] md);
        push_item(CMD_SELECT, $urandom, md, $urandom);
    endtask

    // mostly ticks that walk forward around the period, plus table traffic and reserved codes
    task automatic push_random_item();
        int                pick;
        int                shape;
        logic [TIME_W-1:0] step;
        logic [TIME_W-1:0] off_v;
        pick  = $urandom_range(0, 99);
        shape = $urandom_range(0, 9);
        if (pick < 60)
        begin
            if (period_cur <= 4)
                step = $urandom_range(0, 6);
            else if (shape < 5)
                step = $urandom_range(0, period_cur / 3);
            else if (shape < 8)
                step = period_cur - $urandom_range(0, period_cur / 8)
                       + $urandom_range(0, period_cur / 8);
            else
                step = $urandom;
            wall_ms = wall_ms + step;
            push_tick(wall_ms);
        end
        else if (pick < 78)
        begin
            off_v = (shape < 7) ? TIME_W'($urandom_range(0, period_cur)) : TIME_W'($urandom);
            push_register(MODE_W'($urandom), off_v);
        end
        else if (pick < 95)
        begin
            push_select(MODE_W'($urandom));
        end
        else
        begin
            push_item(CMD_RESERVED, $urandom, MODE_W'($urandom), $urandom);
        end
    endtask

    // block idle: nothing queued, nothing in flight, then a few spare cycles
    // so a tick that reports nothing has surely finished
    task automatic wait_quiet();
        do
            @(posedge clk);
        while (cmd_queue.size() != 0 || start || busy || expected_events.size() != 0);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_period(input logic [TIME_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        period_cur = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int count);
        repeat (count) push_random_item();
        wait_quiet();
    endtask

    // driver: item taken when start and not busy, next one launched from the queue
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                predict_events(command, now_ms, mode, offset_ms);
            if (!start || !busy)
            begin
                if (hold_cycles != 0)
                begin
                    hold_cycles = hold_cycles - 1;
                    start <= 1'b0;
                end
                else if (cmd_queue.size() != 0)
                begin
                    next_item = cmd_queue.pop_front();
                    command   <= next_item.cmd;
                    now_ms    <= next_item.now_val;
                    mode      <= next_item.mode_val;
                    offset_ms <= next_item.off_val;
                    start     <= 1'b1;
                    // idle burst after this item, lands at any point of its work
                    if (!steady && $urandom_range(0, 4) == 0)
                        hold_cycles = $urandom_range(1, 8);
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: every strobe must match the oldest expected event
    always @(posedge clk)
    begin
        if (rst_n && event_strobe)
        begin
            if (expected_events.size() == 0)
            begin
                report_mismatch($sformatf("unexpected event kind %0d slot %0d mode %0d last %0d",
                                          event_kind, slot_index, event_mode, last));
            end
            else
            begin
                want = expected_events.pop_front();
                if (event_kind !== want.kind)
                    report_mismatch($sformatf("event_kind %0d, want %0d", event_kind, want.kind));
                if (slot_index !== want.slot)
                    report_mismatch($sformatf("slot_index %0d, want %0d", slot_index, want.slot));
                if (event_mode !== want.mode_id)
                    report_mismatch($sformatf("event_mode %0d, want %0d", event_mode, want.mode_id));
                if (last !== want.last_flag)
                    report_mismatch($sformatf("last %0d, want %0d", last, want.last_flag));
            end
        end
    end

    // hard stop if the run hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL mode_slot_cyclic_scheduler");
            $finish;
        end
    end

    initial
    begin : stimulus
        int drain;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed part at the reset period of 1000
        push_tick(32'd0);                       // empty active table, nothing to report
        push_register(2'd0, 32'd0);
        push_register(2'd0, 32'hFFFF_FFFF);     // never due
        push_register(2'd0, 32'd100);
        push_register(2'd0, 32'd500);
        push_register(2'd0, 32'd999);
        push_register(2'd0, 32'd7);             // table full, rejected
        push_register(2'd3, 32'd0);
        push_tick(32'd999);                     // just short of the period
        push_tick(32'd1000);                    // period reached, re-arm, slot 0 fires
        push_tick(32'd1600);                    // two slots fire together
        push_tick(32'd2000);                    // overruns then a fire in one item
        push_tick(32'd3001);
        push_select(2'd3);
        push_tick(32'hFFFF_FFFF);
        push_tick(32'd999);                     // time wrapped past zero
        push_item(CMD_RESERVED, 32'hFFFF_FFFF, 2'd3, 32'hFFFF_FFFF);
        push_select(2'd2);                      // empty mode
        push_tick(32'd0);
        push_register(2'd2, 32'hFFFF_FFFF);
        push_register(2'd1, 32'd0);
        push_select(2'd0);
        push_tick(32'h7FFF_FFFF);
        wall_ms = 32'h7FFF_FFFF;
        wait_quiet();

        write_period(32'd50);
        run_random(100);
        write_period(32'd1);                    // smallest nonzero period
        run_random(60);
        write_period(32'd0);                    // zero period, every tick restarts
        run_random(40);
        write_period(32'hFFFF_FFFF);            // largest period
        run_random(60);
        write_period(TIME_W'($urandom_range(100, 5000)));

        // closing phase back to back, no sender gaps
        steady = 1'b1;
        repeat (140) push_random_item();
        do
            @(posedge clk);
        while (cmd_queue.size() != 0 || start);
        drain = 0;
        while ((busy || expected_events.size() != 0) && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (SETTLE_CYC) @(posedge clk);
        if (expected_events.size() != 0)
            report_mismatch($sformatf("%0d expected events never came", expected_events.size()));

        if (mismatch_count == 0)
            $display("PASS mode_slot_cyclic_scheduler");
        else
            $display("FAIL mode_slot_cyclic_scheduler");
        $finish;
    end

endmodule
